### rtl/core/ack_window_tracker_assert.svh
// Assertion macros for the window tracker RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ACK_WINDOW_TRACKER_ASSERT_SVH
`define ACK_WINDOW_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AWT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AWT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/awt_pkg.sv
// Shared types and constants for the acknowledgement window tracker.
// No dependencies; used by awt_step and ack_window_tracker.
package awt_pkg;

  localparam int WINDOW  = 2;
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SEQ_W   = 6;
  localparam int TIMER_W = 8;
  localparam int BYTE_W  = 8;
  localparam int FREE_W  = $clog2(WINDOW + 1);

  localparam logic [BYTE_W-1:0]  ACK_TYPE_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0]  ACK_MARK      = 8'h80;
  localparam logic [SEQ_W-1:0]   WINDOW_SEQ    = SEQ_W'(WINDOW);
  localparam logic [TIMER_W-1:0] RELOAD_RESET  = 8'd3;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_RX   = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EV_SENT    = 2'd0,
    EV_REFUSED = 2'd1,
    EV_BYTE    = 2'd2,
    EV_RETX    = 2'd3
  } event_e;

  typedef struct packed {
    logic               waiting;
    logic [SEQ_W-1:0]   seq;
    logic [TIMER_W-1:0] timer;
  } slot_t;

  typedef struct packed {
    event_e             ev;
    logic [SLOT_W-1:0]  slot;
    logic [SEQ_W-1:0]   seq;
    logic [BYTE_W-1:0]  hdr;
    logic [FREE_W-1:0]  free;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

endpackage

### rtl/core/awt_step.sv
// Next-state and result logic for one request of the window tracker.
// Depends on awt_pkg; purely combinational, registered by the top level.
module awt_step
  import awt_pkg::*;
(
  input  logic [1:0]         kind_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic [TIMER_W-1:0] reload_i,
  input  logic [SEQ_W-1:0]   next_seq_i,
  input  slot_t              slots_i [WINDOW],
  output logic [SEQ_W-1:0]   next_seq_o,
  output slot_t              slots_o [WINDOW],
  output step_out_t          out_o
);

  logic              found;
  logic [FREE_W-1:0] free_cnt;
  logic [SEQ_W-1:0]  ack_seq;
  step_out_t         res;

  assign ack_seq = rx_byte_i[SEQ_W-1:0];

  always_comb begin
    found      = 1'b0;
    free_cnt   = '0;
    res        = '0;
    next_seq_o = next_seq_i;
    for (int i = 0; i < WINDOW; i++) begin
      slots_o[i] = slots_i[i];
    end

    case (kind_i)
      KIND_SEND: begin
        // Lowest-numbered free slot wins.
        for (int i = 0; i < WINDOW; i++) begin
          if (!found && !slots_i[i].waiting) begin
            found            = 1'b1;
            slots_o[i].waiting = 1'b1;
            slots_o[i].seq   = next_seq_i;
            slots_o[i].timer = reload_i;
            next_seq_o       = next_seq_i + SEQ_W'(1);
            res.first.slot   = SLOT_W'(i);
            res.first.seq    = next_seq_i;
            res.first.hdr    = ACK_MARK | BYTE_W'(next_seq_i);
          end
        end
        res.first.ev   = found ? EV_SENT : EV_REFUSED;
        res.first.last = 1'b1;
        res.count      = 2'd1;
      end
      KIND_RX: begin
        // An ack frees every slot within the window behind the acked number.
        if ((rx_byte_i & ACK_TYPE_MASK) == ACK_MARK) begin
          for (int i = 0; i < WINDOW; i++) begin
            if (slots_i[i].waiting && ((ack_seq - slots_i[i].seq) < WINDOW_SEQ)) begin
              slots_o[i].waiting = 1'b0;
            end
          end
        end
        res.first.ev   = EV_BYTE;
        res.first.last = 1'b1;
        res.count      = 2'd1;
      end
      KIND_TICK: begin
        for (int i = 0; i < WINDOW; i++) begin
          if (slots_i[i].waiting) begin
            if (slots_i[i].timer <= TIMER_W'(1)) begin
              slots_o[i].timer = reload_i;
              if (res.count == 2'd0) begin
                res.first.ev   = EV_RETX;
                res.first.slot = SLOT_W'(i);
                res.first.seq  = slots_i[i].seq;
                res.first.hdr  = ACK_MARK | BYTE_W'(slots_i[i].seq);
              end else begin
                res.second.ev   = EV_RETX;
                res.second.slot = SLOT_W'(i);
                res.second.seq  = slots_i[i].seq;
                res.second.hdr  = ACK_MARK | BYTE_W'(slots_i[i].seq);
              end
              res.count = res.count + 2'd1;
            end else begin
              slots_o[i].timer = slots_i[i].timer - TIMER_W'(1);
            end
          end
        end
        res.first.last  = (res.count == 2'd1);
        res.second.last = (res.count == 2'd2);
      end
      default: begin
      end
    endcase

    for (int i = 0; i < WINDOW; i++) begin
      free_cnt = free_cnt + FREE_W'(!slots_o[i].waiting);
    end
    res.first.free  = free_cnt;
    res.second.free = free_cnt;
    out_o = res;
  end

endmodule

### rtl/core/ack_window_tracker.sv
// Top level of the go-back-N acknowledgement window tracker.
// Depends on awt_pkg, awt_step and ack_window_tracker_assert.svh.
//
//  Channel    | Ports                                        | Handshake
//  -----------+----------------------------------------------+----------------------------
//  request    | kind_i, rx_byte_i                            | start_i high, busy_o low
//  result     | event_res_o .. last_o                        | result_valid_o, one cycle
//  config     | timeout_reload_i                             | timeout_reload_we_i high
//
// A request's first result appears in the cycle after it is accepted; a tick
// with no expiry gives none. A tick that expires both slots makes a second
// result in the cycle after the first; busy_o is high while the first is shown,
// so the sustained rate is one request per cycle while busy_o is low. The
// results leave through a single output register. After reset all slots are
// free, the next sequence number is zero and the timeout is three. The
// receiver cannot stall: every result is shown for exactly one cycle.
`include "ack_window_tracker_assert.svh"

module ack_window_tracker
  import awt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         kind_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic               timeout_reload_we_i,
  input  logic [TIMER_W-1:0] timeout_reload_i,
  output logic               result_valid_o,
  output logic [1:0]         event_res_o,
  output logic [SLOT_W-1:0]  slot_index_o,
  output logic [SEQ_W-1:0]   seq_number_o,
  output logic [BYTE_W-1:0]  header_byte_o,
  output logic [FREE_W-1:0]  free_count_o,
  output logic               last_o
);

  // Slot state, sequence counter and the timeout register.
  slot_t              slots_q [WINDOW];
  slot_t              slots_d [WINDOW];
  logic [SEQ_W-1:0]   next_seq_q;
  logic [SEQ_W-1:0]   next_seq_d;
  logic [TIMER_W-1:0] reload_q;

  // Output register and the held second result of a double expiry.
  result_t            res_q;
  result_t            pend_q;
  logic               res_valid_q;
  logic               pend_valid_q;

  step_out_t          step;
  logic               accept;

  // While a second result waits, no new request can be taken.
  assign busy_o = pend_valid_q;
  assign accept = start_i && !busy_o;

  awt_step u_step (
    .kind_i     (kind_i),
    .rx_byte_i  (rx_byte_i),
    .reload_i   (reload_q),
    .next_seq_i (next_seq_q),
    .slots_i    (slots_q),
    .next_seq_o (next_seq_d),
    .slots_o    (slots_d),
    .out_o      (step)
  );

  // Control state and slot bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        slots_q[i] <= '0;
      end
      next_seq_q   <= '0;
      reload_q     <= RELOAD_RESET;
      res_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (timeout_reload_we_i) begin
        reload_q <= timeout_reload_i;
      end
      if (accept) begin
        for (int i = 0; i < WINDOW; i++) begin
          slots_q[i] <= slots_d[i];
        end
        next_seq_q   <= next_seq_d;
        res_valid_q  <= (step.count != 2'd0);
        pend_valid_q <= (step.count == 2'd2);
      end else if (pend_valid_q) begin
        res_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else begin
        res_valid_q  <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; the strobe qualifies it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= step.first;
      pend_q <= step.second;
    end else if (pend_valid_q) begin
      res_q  <= pend_q;
    end
  end

  assign result_valid_o = res_valid_q;
  assign event_res_o    = res_q.ev;
  assign slot_index_o   = res_q.slot;
  assign seq_number_o   = res_q.seq;
  assign header_byte_o  = res_q.hdr;
  assign free_count_o   = res_q.free;
  assign last_o         = res_q.last;

  // A held second result always follows a shown first result.
  `AWT_ASSERT_IMP(a_pend_has_first, pend_valid_q, res_valid_q && !res_q.last, "pending result without first result")
  // The cycle after busy shows the final retransmit result.
  `AWT_ASSERT_NXT(a_busy_then_last, busy_o, result_valid_o && last_o && (event_res_o == EV_RETX), "second result missing after busy")
  // An accepted send always answers in the next cycle with one final result.
  `AWT_ASSERT_NXT(a_send_answers, accept && (kind_i == KIND_SEND), result_valid_o && last_o && !busy_o, "send request without single result")
  // Retransmit headers carry the ack mark and the slot's sequence number.
  `AWT_ASSERT_IMP(a_retx_header, result_valid_o && (event_res_o == EV_RETX), header_byte_o == (ACK_MARK | BYTE_W'(seq_number_o)), "retransmit header mismatch")

endmodule
